// ----- src/thbd_pkg.sv -----
// Package for the tap/hold button detector.
// Holds the shared constants, the sequencer state type and the state-update struct.
// Has no dependencies.
package thbd_pkg;

	// Number of buttons scanned per item and the width of a button index.
	localparam int NumButtons = 32;
	localparam int IdxW       = 5;

	// Field widths.
	localparam int TimeW = 48;
	localparam int MaskW = 32;
	localparam int ThrW  = 32;

	// Configuration register indexes.
	localparam logic RegHoldThr = 1'b0;
	localparam logic RegTapThr  = 1'b1;

	// Event kinds.
	localparam logic EvTap  = 1'b0;
	localparam logic EvHold = 1'b1;

	// Sequencer states.
	typedef enum logic [1:0] {
		StIdle,
		StScan,
		StFlush
	} state_t;

	// Update applied to one button's stored state.
	typedef struct packed {
		logic set_start;
		logic clear;
		logic set_hold;
	} upd_t;

endpackage

// ----- src/tap_hold_button_detector_unit.sv -----
// Tap/hold button detector: scans the 32 buttons of an item one per cycle unless an event
// finds the output register full; an item is taken only once the previous scan ends.
// A single shared duration subtractor evaluates the buttons in turn.
// Reset clears the sequencer, the valid and hold-sent flags and both thresholds to zero.
module tap_hold_button_detector_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_idx,
	input  logic [thbd_pkg::ThrW-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [thbd_pkg::MaskW-1:0]  previous_buttons,
	input  logic [thbd_pkg::MaskW-1:0]  current_buttons,
	input  logic [thbd_pkg::TimeW-1:0]  sample_time,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        event_kind,
	output logic [thbd_pkg::IdxW-1:0]   button_index,
	output logic [thbd_pkg::TimeW-1:0]  event_time,
	output logic [thbd_pkg::MaskW-1:0]  modifier_mask,
	output logic                        last_event
);

	thbd_pkg::state_t state_q, state_d;

	logic [thbd_pkg::ThrW-1:0]  hold_thr_q;
	logic [thbd_pkg::ThrW-1:0]  tap_thr_q;
	logic [thbd_pkg::MaskW-1:0] prev_q;
	logic [thbd_pkg::MaskW-1:0] cur_q;
	logic [thbd_pkg::TimeW-1:0] now_q;
	logic [thbd_pkg::IdxW-1:0]  idx_q;

	logic                       pend_valid_q;
	logic                       pend_kind_q;
	logic [thbd_pkg::IdxW-1:0]  pend_idx_q;
	logic [thbd_pkg::MaskW-1:0] pend_mask_q;

	logic                       out_valid_q;
	logic                       out_kind_q;
	logic [thbd_pkg::IdxW-1:0]  out_idx_q;
	logic [thbd_pkg::TimeW-1:0] out_time_q;
	logic [thbd_pkg::MaskW-1:0] out_mask_q;
	logic                       out_last_q;

	logic                       accept;
	logic                       slot_free;
	logic                       scan_step;
	logic                       push;
	logic                       push_last;
	logic                       load_pend;
	logic                       flush_done;
	logic                       last_idx;

	logic [thbd_pkg::TimeW-1:0] st_start;
	logic                       st_hold;
	logic                       ev_hit;
	logic                       ev_kind;
	thbd_pkg::upd_t             upd;
	logic [thbd_pkg::MaskW-1:0] own_bit;
	logic [thbd_pkg::MaskW-1:0] ev_mask;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_thr_q <= '0;
			tap_thr_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				thbd_pkg::RegHoldThr: hold_thr_q <= cfg_wdata;
				thbd_pkg::RegTapThr:  tap_thr_q  <= cfg_wdata;
				default:              hold_thr_q <= hold_thr_q;
			endcase
		end
	end

	// Button state store and the shared evaluation unit.
	thbd_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.idx       (idx_q),
		.we        (scan_step),
		.upd       (upd),
		.now       (now_q),
		.start     (st_start),
		.hold_sent (st_hold)
	);

	thbd_eval u_eval (
		.was       (prev_q[idx_q]),
		.is_down   (cur_q[idx_q]),
		.start     (st_start),
		.hold_sent (st_hold),
		.now       (now_q),
		.hold_thr  (hold_thr_q),
		.tap_thr   (tap_thr_q),
		.ev_hit    (ev_hit),
		.ev_kind   (ev_kind),
		.upd       (upd)
	);

	// Other pressed buttons, own bit cleared.
	assign own_bit = thbd_pkg::MaskW'(1) << idx_q;
	assign ev_mask = ((ev_kind == thbd_pkg::EvHold) ? cur_q : prev_q) & ~own_bit;

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign last_idx  = (idx_q == thbd_pkg::IdxW'(thbd_pkg::NumButtons - 1));

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			thbd_pkg::StIdle:  if (in_valid) state_d = thbd_pkg::StScan;
			thbd_pkg::StScan:  if (scan_step && last_idx) state_d = thbd_pkg::StFlush;
			thbd_pkg::StFlush: if (flush_done) state_d = thbd_pkg::StIdle;
			default:           state_d = thbd_pkg::StIdle;
		endcase
	end

	// Sequencer outputs. One event is held back so the final one can be marked.
	always_comb begin
		in_ready   = 1'b0;
		scan_step  = 1'b0;
		push       = 1'b0;
		push_last  = 1'b0;
		load_pend  = 1'b0;
		flush_done = 1'b0;
		unique case (state_q)
			thbd_pkg::StIdle: begin
				in_ready = 1'b1;
			end
			thbd_pkg::StScan: begin
				if (!(ev_hit && pend_valid_q && !slot_free)) begin
					scan_step = 1'b1;
					push      = ev_hit && pend_valid_q;
					load_pend = ev_hit;
				end
			end
			thbd_pkg::StFlush: begin
				if (!pend_valid_q) begin
					flush_done = 1'b1;
				end else if (slot_free) begin
					push       = 1'b1;
					push_last  = 1'b1;
					flush_done = 1'b1;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= thbd_pkg::StIdle;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= '0;
			end else if (scan_step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (accept || flush_done) begin
				pend_valid_q <= 1'b0;
			end else if (load_pend) begin
				pend_valid_q <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, pending event and output payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_q <= previous_buttons;
			cur_q  <= current_buttons;
			now_q  <= sample_time;
		end
		if (load_pend) begin
			pend_kind_q <= ev_kind;
			pend_idx_q  <= idx_q;
			pend_mask_q <= ev_mask;
		end
		if (push) begin
			out_kind_q <= pend_kind_q;
			out_idx_q  <= pend_idx_q;
			out_time_q <= now_q;
			out_mask_q <= pend_mask_q;
			out_last_q <= push_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = out_kind_q;
	assign button_index  = out_idx_q;
	assign event_time    = out_time_q;
	assign modifier_mask = out_mask_q;
	assign last_event    = out_last_q;

endmodule

// ----- src/thbd_eval.sv -----
// Shared evaluation unit: one 48-bit subtractor and threshold compares.
// Decides the event and the state update for the button under scan.
// Depends on thbd_pkg.
module thbd_eval (
	input  logic                         was,
	input  logic                         is_down,
	input  logic [thbd_pkg::TimeW-1:0]   start,
	input  logic                         hold_sent,
	input  logic [thbd_pkg::TimeW-1:0]   now,
	input  logic [thbd_pkg::ThrW-1:0]    hold_thr,
	input  logic [thbd_pkg::ThrW-1:0]    tap_thr,
	output logic                         ev_hit,
	output logic                         ev_kind,
	output thbd_pkg::upd_t               upd
);

	logic [thbd_pkg::TimeW:0]   diff;
	logic [thbd_pkg::TimeW-1:0] dur;
	logic                       in_order;
	logic                       armed;
	logic                       hold_ok;
	logic                       tap_ok;

	// Held duration; the extra top bit flags time going backwards.
	assign diff     = {1'b0, now} - {1'b0, start};
	assign dur      = diff[thbd_pkg::TimeW-1:0];
	assign in_order = ~diff[thbd_pkg::TimeW];
	assign armed    = (start != '0) && !hold_sent && in_order;

	// Duration against the thresholds; the upper bits exceed any 32-bit threshold.
	assign hold_ok = (dur[thbd_pkg::TimeW-1:thbd_pkg::ThrW] != '0) ||
		(dur[thbd_pkg::ThrW-1:0] >= hold_thr);
	assign tap_ok  = (dur[thbd_pkg::TimeW-1:thbd_pkg::ThrW] == '0) &&
		(dur[thbd_pkg::ThrW-1:0] <= tap_thr);

	// Decide per combination of the previous and current level.
	always_comb begin
		ev_hit  = 1'b0;
		ev_kind = thbd_pkg::EvTap;
		upd     = '0;
		case ({is_down, was})
			2'b10: begin
				upd.set_start = 1'b1;
			end
			2'b11: begin
				if (armed && hold_ok) begin
					ev_hit       = 1'b1;
					ev_kind      = thbd_pkg::EvHold;
					upd.set_hold = 1'b1;
				end
			end
			2'b01: begin
				upd.clear = 1'b1;
				if (armed && tap_ok) begin
					ev_hit  = 1'b1;
					ev_kind = thbd_pkg::EvTap;
				end
			end
			default: begin
				ev_hit = 1'b0;
			end
		endcase
	end

endmodule

// ----- src/thbd_state.sv -----
// Per-button state store: press start times, valid bits and hold-sent flags.
// Start times sit in a plain array; valid bits make an unwritten entry read as zero.
// Depends on thbd_pkg.
module thbd_state (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [thbd_pkg::IdxW-1:0]   idx,
	input  logic                        we,
	input  thbd_pkg::upd_t              upd,
	input  logic [thbd_pkg::TimeW-1:0]  now,
	output logic [thbd_pkg::TimeW-1:0]  start,
	output logic                        hold_sent
);

	logic [thbd_pkg::TimeW-1:0]    start_mem [thbd_pkg::NumButtons];
	logic [thbd_pkg::NumButtons-1:0] valid_q;
	logic [thbd_pkg::NumButtons-1:0] hold_q;

	// Start time storage, no reset needed behind the valid bits.
	always_ff @(posedge clk) begin
		if (we && upd.set_start) begin
			start_mem[idx] <= now;
		end
	end

	// Valid and hold-sent flags, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hold_q  <= '0;
		end else if (we) begin
			if (upd.set_start) begin
				valid_q[idx] <= 1'b1;
				hold_q[idx]  <= 1'b0;
			end else if (upd.clear) begin
				valid_q[idx] <= 1'b0;
				hold_q[idx]  <= 1'b0;
			end else if (upd.set_hold) begin
				hold_q[idx] <= 1'b1;
			end
		end
	end

	// A button without a recorded press reads as start time zero.
	assign start     = valid_q[idx] ? start_mem[idx] : '0;
	assign hold_sent = hold_q[idx];

endmodule

// ----- tb/sv/tb_tap_hold_button_detector_unit.sv -----
// Testbench for tap_hold_button_detector_unit: a directed table of samples, then random sample
// streams under several thresholds, checked by an in-bench tap/hold predictor or the table.
// Depends on thbd_pkg and the detector RTL.
module tb_tap_hold_button_detector_unit;

	localparam int ClockPeriod    = 10;
	localparam int DrainCycles    = 40;
	localparam int LongHoldCycles = 300;
	localparam int Segments       = 6;
	localparam int SegItems       = 58;
	localparam int PressureSeg    = 1;
	localparam int LimitCycles    = 2_000_000;

	// One tap or hold event as it leaves the block.
	typedef struct packed {
		logic                          kind;
		logic [thbd_pkg::IdxW-1:0]     idx;
		logic [thbd_pkg::TimeW-1:0]    t;
		logic [thbd_pkg::MaskW-1:0]    mods;
		logic                          last;
	} button_event_t;

	// A table row is either one sample or a pair of threshold writes.
	typedef enum logic {RowItem, RowThr} row_kind_t;
	// How the events of a sample are found: from the predictor, none, or one typed in.
	typedef enum logic [1:0] {ExpModel, ExpNone, ExpOne} row_check_t;

	typedef struct packed {
		row_kind_t                     kind;
		logic [thbd_pkg::ThrW-1:0]     hold;
		logic [thbd_pkg::ThrW-1:0]     tap;
		logic [thbd_pkg::MaskW-1:0]    prev;
		logic [thbd_pkg::MaskW-1:0]    cur;
		logic [thbd_pkg::TimeW-1:0]    t;
		row_check_t                    check;
		button_event_t                 ev;
	} script_row_t;

	localparam button_event_t NoEvent = '0;
	localparam int ScriptLen = 27;

	localparam script_row_t Script [ScriptLen] = '{
		// Idle sample, then every button pressed at time zero, which counts as no press.
		'{RowItem, 32'd0, 32'd0, 32'h0000_0000, 32'h0000_0000, 48'd0, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'h0000_0000, 32'hFFFF_FFFF, 48'd0, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd5, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'h0000_0000, 48'd5, ExpNone, NoEvent},
		// Zero thresholds: hold on the first held sample, tap on an instant release.
		'{RowItem, 32'd0, 32'd0, 32'h0000_0000, 32'h0000_0001, 48'd100, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'h0000_0001, 32'h0000_0001, 48'd100, ExpOne,
			'{thbd_pkg::EvHold, 5'd0, 48'd100, 32'h0000_0000, 1'b1}},
		'{RowItem, 32'd0, 32'd0, 32'h0000_0001, 32'h0000_0000, 48'd100, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'h0000_0000, 32'h8000_0000, 48'd200, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'h8000_0000, 32'h0000_0000, 48'd200, ExpOne,
			'{thbd_pkg::EvTap, 5'd31, 48'd200, 32'h0000_0000, 1'b1}},
		// Largest thresholds; one sample gives an event for every button.
		'{RowThr, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 48'd0, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'h0000_0000, 32'hFFFF_FFFF, 48'h1_0000_0000, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h1_FFFF_FFFE, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 48'h1_FFFF_FFFF, ExpModel, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h0000_0000, 48'h2_0000_0000, ExpNone, NoEvent},
		// Press at the largest time, then time going backwards while held and on release.
		'{RowItem, 32'd0, 32'd0, 32'h0000_0000, 32'h0000_0002, 48'hFFFF_FFFF_FFFF, ExpNone,
			NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'h0000_0002, 32'h0000_0002, 48'd10, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'h0000_0002, 32'h0000_0000, 48'd20, ExpNone, NoEvent},
		// Mid thresholds: hold and tap exactly at their limits, a release one past the tap limit.
		'{RowThr, 32'd10, 32'd5, 32'd0, 32'd0, 48'd0, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'h0000_0000, 32'h0000_0004, 48'd1000, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'h0000_0004, 32'h0000_000C, 48'd1009, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'h0000_000C, 32'h0000_000C, 48'd1010, ExpOne,
			'{thbd_pkg::EvHold, 5'd2, 48'd1010, 32'h0000_0008, 1'b1}},
		'{RowItem, 32'd0, 32'd0, 32'h0000_000C, 32'h0000_0004, 48'd1014, ExpOne,
			'{thbd_pkg::EvTap, 5'd3, 48'd1014, 32'h0000_0004, 1'b1}},
		'{RowItem, 32'd0, 32'd0, 32'h0000_0004, 32'h0000_0014, 48'd1020, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'h0000_0014, 32'h0000_0004, 48'd1026, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'h0000_0004, 32'h0000_0000, 48'd1030, ExpNone, NoEvent},
		// Held in both masks without a recorded press, then a mixed sample.
		'{RowItem, 32'd0, 32'd0, 32'h0000_0001, 32'h0000_0001, 48'd50, ExpNone, NoEvent},
		'{RowItem, 32'd0, 32'd0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 48'h8000_0000_0001, ExpModel,
			NoEvent}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we;
	logic                          cfg_idx;
	logic [thbd_pkg::ThrW-1:0]     cfg_wdata;
	logic                          in_valid;
	logic                          in_ready;
	logic [thbd_pkg::MaskW-1:0]    previous_buttons;
	logic [thbd_pkg::MaskW-1:0]    current_buttons;
	logic [thbd_pkg::TimeW-1:0]    sample_time;
	logic                          out_valid;
	logic                          out_ready;
	logic                          event_kind;
	logic [thbd_pkg::IdxW-1:0]     button_index;
	logic [thbd_pkg::TimeW-1:0]    event_time;
	logic [thbd_pkg::MaskW-1:0]    modifier_mask;
	logic                          last_event;

	// Per-item check mode, carried alongside the payload.
	row_check_t                    row_check = ExpModel;
	button_event_t                 row_event = '0;

	// Predictor state: thresholds, press start times and hold flags.
	logic [thbd_pkg::ThrW-1:0]     hold_thr = '0;
	logic [thbd_pkg::ThrW-1:0]     tap_thr = '0;
	logic [thbd_pkg::TimeW-1:0]    press_at [thbd_pkg::NumButtons] = '{default: '0};
	logic                          hold_fired [thbd_pkg::NumButtons] = '{default: 1'b0};
	button_event_t                 sample_events [$];
	button_event_t                 awaited_events [$];
	int                            mismatches = 0;

	// Stimulus state shared by the sender and the receiver.
	bit                            idle_on = 1'b1;
	bit                            hold_req = 1'b0;
	logic [thbd_pkg::ThrW-1:0]     seg_hold;
	logic [thbd_pkg::ThrW-1:0]     seg_tap;
	logic [thbd_pkg::MaskW-1:0]    stream_mask = '0;
	logic [thbd_pkg::MaskW-1:0]    active_mask = '1;
	logic [thbd_pkg::TimeW-1:0]    stream_now = '0;

	tap_hold_button_detector_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.previous_buttons (previous_buttons),
		.current_buttons  (current_buttons),
		.sample_time      (sample_time),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.event_kind       (event_kind),
		.button_index     (button_index),
		.event_time       (event_time),
		.modifier_mask    (modifier_mask),
		.last_event       (last_event)
	);

	always #(ClockPeriod / 2) clk = ~clk;

	// Scan one sample over all buttons in ascending order and collect its events.
	function automatic void scan_sample(input logic [thbd_pkg::MaskW-1:0] prev,
			input logic [thbd_pkg::MaskW-1:0] cur, input logic [thbd_pkg::TimeW-1:0] now);
		logic [thbd_pkg::TimeW-1:0] start;
		logic [thbd_pkg::MaskW-1:0] bit_mask;
		button_event_t ev;
		sample_events.delete();
		for (int i = 0; i < thbd_pkg::NumButtons; i++) begin
			start = press_at[i];
			bit_mask = thbd_pkg::MaskW'(1) << i;
			if (cur[i] && !prev[i]) begin
				press_at[i] = now;
				hold_fired[i] = 1'b0;
			end else if (cur[i]) begin
				if (start != '0 && !hold_fired[i] && now >= start &&
						now - start >= thbd_pkg::TimeW'(hold_thr)) begin
					ev = '{thbd_pkg::EvHold, thbd_pkg::IdxW'(i), now, cur & ~bit_mask, 1'b0};
					sample_events.push_back(ev);
					hold_fired[i] = 1'b1;
				end
			end else if (prev[i]) begin
				if (start != '0 && !hold_fired[i] && now >= start &&
						now - start <= thbd_pkg::TimeW'(tap_thr)) begin
					ev = '{thbd_pkg::EvTap, thbd_pkg::IdxW'(i), now, prev & ~bit_mask, 1'b0};
					sample_events.push_back(ev);
				end
				press_at[i] = '0;
				hold_fired[i] = 1'b0;
			end
		end
		if (sample_events.size() > 0)
			sample_events[sample_events.size() - 1].last = 1'b1;
	endfunction

	function automatic void note_mismatch(input string what, input button_event_t want,
			input button_event_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected kind %0d idx %0d time %h mods %h last %0d, %s",
				what, want.kind, want.idx, want.t, want.mods, want.last,
				$sformatf("got kind %0d idx %0d time %h mods %h last %0d",
					got.kind, got.idx, got.t, got.mods, got.last));
	endfunction

	// Compare one accepted event against the oldest expected one.
	function automatic void check_event();
		button_event_t got;
		button_event_t want;
		got = '{event_kind, button_index, event_time, modifier_mask, last_event};
		if (awaited_events.size() == 0) begin
			note_mismatch("unexpected event", NoEvent, got);
		end else begin
			want = awaited_events.pop_front();
			if (got.kind != want.kind || got.idx != want.idx || got.t != want.t ||
					got.mods != want.mods || got.last != want.last)
				note_mismatch("event mismatch", want, got);
		end
	endfunction

	// Track register writes, predict accepted items and check accepted events.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_idx == thbd_pkg::RegHoldThr)
					hold_thr = cfg_wdata;
				else if (cfg_idx == thbd_pkg::RegTapThr)
					tap_thr = cfg_wdata;
			end
			if (in_valid && in_ready) begin
				scan_sample(previous_buttons, current_buttons, sample_time);
				case (row_check)
					ExpModel: begin
						foreach (sample_events[k])
							awaited_events.push_back(sample_events[k]);
					end
					ExpOne: begin
						awaited_events.push_back(row_event);
					end
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready)
				check_event();
		end
	end

	// Offer one item and return at the edge where it is taken.
	task automatic offer_item(input logic [thbd_pkg::MaskW-1:0] prev,
			input logic [thbd_pkg::MaskW-1:0] cur, input logic [thbd_pkg::TimeW-1:0] t,
			input row_check_t check, input button_event_t ev);
		previous_buttons <= prev;
		current_buttons <= cur;
		sample_time <= t;
		row_check <= check;
		row_event <= ev;
		in_valid <= 1'b1;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	task automatic maybe_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Stop offering, wait for every expected event, then let any silent scan finish.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_events.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_thresholds(input logic [thbd_pkg::ThrW-1:0] hold,
			input logic [thbd_pkg::ThrW-1:0] tap);
		cfg_we <= 1'b1;
		cfg_idx <= thbd_pkg::RegHoldThr;
		cfg_wdata <= hold;
		@(posedge clk);
		cfg_idx <= thbd_pkg::RegTapThr;
		cfg_wdata <= tap;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [thbd_pkg::ThrW-1:0] pick_thr();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(1, 20);
			3: return $urandom_range(100, 5000);
			default: return $urandom;
		endcase
	endfunction

	// Time advance between samples, mostly near the current thresholds.
	function automatic logic [thbd_pkg::TimeW-1:0] pick_step();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return thbd_pkg::TimeW'($urandom_range(1, 3));
			2: return thbd_pkg::TimeW'(seg_hold) + thbd_pkg::TimeW'($urandom_range(0, 2)) -
				thbd_pkg::TimeW'(1);
			3: return thbd_pkg::TimeW'(seg_tap) + thbd_pkg::TimeW'($urandom_range(0, 2)) -
				thbd_pkg::TimeW'(1);
			4: return thbd_pkg::TimeW'($urandom) %
				(thbd_pkg::TimeW'(seg_hold) + thbd_pkg::TimeW'(1));
			5: return thbd_pkg::TimeW'($urandom) %
				(thbd_pkg::TimeW'(seg_tap) + thbd_pkg::TimeW'(1));
			default: return thbd_pkg::TimeW'($urandom);
		endcase
	endfunction

	// Mostly consistent streams where prev is the last cur; some noise and broken samples.
	task automatic compose_sample(output logic [thbd_pkg::MaskW-1:0] prev,
			output logic [thbd_pkg::MaskW-1:0] cur, output logic [thbd_pkg::TimeW-1:0] t);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			prev = $urandom;
			cur = $urandom;
			t = {16'($urandom), 32'($urandom)};
		end else if (roll < 17) begin
			prev = stream_mask ^ ($urandom & $urandom);
			cur = stream_mask ^ ($urandom & $urandom);
			stream_now = stream_now - thbd_pkg::TimeW'($urandom_range(0, 40));
			t = stream_now;
		end else if (roll < 19) begin
			prev = stream_mask;
			cur = stream_mask ^ ($urandom & $urandom & active_mask);
			stream_now = '0;
			t = stream_now;
		end else begin
			prev = stream_mask;
			cur = stream_mask ^ ($urandom & $urandom & active_mask);
			stream_now = stream_now + pick_step();
			t = stream_now;
		end
		stream_mask = cur;
	endtask

	// Event receiver: random stall bursts, one long hold-off on request.
	initial begin : sink
		int unsigned span;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				for (int c = 1; c < LongHoldCycles; c++)
					@(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				span = $urandom_range(1, 19);
				out_ready <= 1'b0;
				repeat (span - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Sample sender: reset, directed table, random segments, final check.
	initial begin : stimulus
		script_row_t row;
		logic [thbd_pkg::MaskW-1:0] prev;
		logic [thbd_pkg::MaskW-1:0] cur;
		logic [thbd_pkg::TimeW-1:0] t;
		int burst_left;
		burst_left = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= thbd_pkg::RegHoldThr;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		previous_buttons <= '0;
		current_buttons <= '0;
		sample_time <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (int r = 0; r < ScriptLen; r++) begin
			row = Script[r];
			if (row.kind == RowThr) begin
				drain_results();
				set_thresholds(row.hold, row.tap);
			end else begin
				maybe_gap();
				offer_item(row.prev, row.cur, row.t, row.check, row.ev);
			end
		end

		// Random segments, each under its own pair of thresholds; the last one without idling.
		for (int seg = 0; seg < Segments; seg++) begin
			drain_results();
			if (seg == PressureSeg) begin
				seg_hold = 32'd2;
				seg_tap = 32'd50;
			end else begin
				seg_hold = pick_thr();
				seg_tap = pick_thr();
			end
			set_thresholds(seg_hold, seg_tap);
			active_mask = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom;
			case ($urandom_range(0, 2))
				0: stream_now = thbd_pkg::TimeW'($urandom_range(1, 1000));
				1: stream_now = {16'($urandom), 32'($urandom)};
				default: stream_now = 48'hFFFF_FFFF_FFFF -
					thbd_pkg::TimeW'($urandom_range(0, 5000));
			endcase
			idle_on = (seg != Segments - 1);
			for (int k = 0; k < SegItems; k++) begin
				if (seg != Segments - 1 && $urandom_range(0, 24) == 0)
					idle_on = !idle_on;
				// Stall the receiver for a long stretch and keep offering items back to back.
				if (seg == PressureSeg && k == 20) begin
					hold_req = 1'b1;
					burst_left = 15;
				end
				if (burst_left > 0)
					burst_left--;
				else
					maybe_gap();
				compose_sample(prev, cur, t);
				offer_item(prev, cur, t, ExpModel, NoEvent);
			end
		end

		drain_results();
		if (mismatches == 0 && awaited_events.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Run limit.
	initial begin : watchdog
		#(LimitCycles * ClockPeriod);
		$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
src/thbd_pkg.sv
src/thbd_eval.sv
src/thbd_state.sv
src/tap_hold_button_detector_unit.sv
tb/sv/tb_tap_hold_button_detector_unit.sv
